// File: hw/rtl/rrp_pkg.sv
// read row packer package: sizes, constants and the transfer structs
// used by rrp_front, rrp_back and read_row_packer_core; no dependencies
package rrp_pkg;

    localparam int NUM_REFS = 16;
    localparam int MAX_ROWS = 1024;
    localparam int REF_W    = 4;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = ROW_W + 1;
    localparam int POS_W    = 31;
    localparam int END_W    = 32;
    localparam int ADDR_W   = REF_W + ROW_W;

    localparam logic [POS_W-1:0] COL_DIST_RESET = POS_W'(100000);

    typedef struct packed {
        logic             mapped;
        logic [3:0]       reference_id;
        logic [POS_W-1:0] start_position;
        logic [POS_W-1:0] read_length;
    } rrp_in_t;

    typedef struct packed {
        logic [9:0]       packed_row;
        logic [END_W-1:0] end_position;
        logic [END_W-1:0] max_end;
        logic [POS_W-1:0] max_length;
        logic             overflow;
    } rrp_out_t;

    typedef struct packed {
        logic [REF_W-1:0] ref_id;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] read_len;
        logic [END_W-1:0] end_pos;
    } rrp_job_t;

endpackage

// File: hw/rtl/rrp_front.sv
// front end: accepts reads, drops unmapped ones, forms the end position
// and holds jobs in a two-entry queue; depends on rrp_pkg
module rrp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rrp_pkg::rrp_in_t  in_data,
    output logic              job_valid,
    input  logic              job_pop,
    output rrp_pkg::rrp_job_t job
);

    rrp_pkg::rrp_job_t q_mem [2];
    rrp_pkg::rrp_job_t new_job;
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              accept;
    logic              push;
    logic              pop;

    assign in_stall  = (count_reg == 2'd2);
    assign accept    = in_valid && !in_stall;
    assign push      = accept && in_data.mapped
                       && (32'(in_data.reference_id) < 32'(rrp_pkg::NUM_REFS));
    assign pop       = job_pop && (count_reg != 2'd0);
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_mem[rd_ptr_reg];

    always_comb
    begin
        new_job.ref_id    = rrp_pkg::REF_W'(in_data.reference_id);
        new_job.start_pos = in_data.start_position;
        new_job.read_len  = in_data.read_length;
        new_job.end_pos   = {1'b0, in_data.start_position} + {1'b0, in_data.read_length};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: hw/rtl/rrp_back.sv
// back end: per-reference row state, row end memory, row search walk and
// the result register; depends on rrp_pkg
module rrp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [30:0]       cfg_data,
    input  logic              job_valid,
    output logic              job_pop,
    input  rrp_pkg::rrp_job_t job,
    output logic              out_valid,
    input  logic              out_stall,
    output rrp_pkg::rrp_out_t out_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETUP  = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    localparam int RW = rrp_pkg::ROW_W;
    localparam int CW = rrp_pkg::CNT_W;
    localparam int PW = rrp_pkg::POS_W;
    localparam int EW = rrp_pkg::END_W;

    localparam logic [RW-1:0] LAST_ROW = RW'(rrp_pkg::MAX_ROWS - 1);

    logic [EW-1:0] row_mem [rrp_pkg::NUM_REFS * rrp_pkg::MAX_ROWS];

    logic [1:0]              state_reg;
    rrp_pkg::rrp_job_t       job_reg;
    logic [RW-1:0]           cur_reg;
    logic                    ovf_reg;
    logic [EW-1:0]           rd_data_reg;
    logic [PW-1:0]           col_dist_reg;
    logic                    out_valid_reg;
    rrp_pkg::rrp_out_t       out_data_reg;

    logic [CW-1:0] row_count_reg      [rrp_pkg::NUM_REFS];
    logic [RW-1:0] row_cursor_reg     [rrp_pkg::NUM_REFS];
    logic [PW-1:0] column_start_reg   [rrp_pkg::NUM_REFS];
    logic [EW-1:0] largest_end_reg    [rrp_pkg::NUM_REFS];
    logic [PW-1:0] largest_length_reg [rrp_pkg::NUM_REFS];

    logic [PW-1:0] col_start;
    logic          col_reset;
    logic [RW-1:0] cur_first;
    logic [CW-1:0] cnt;
    logic          occupied;
    logic          is_last;
    logic [RW-1:0] rd_row;
    logic          out_free;
    logic          commit;
    logic          wr_en;
    logic [EW-1:0] max_end_next;
    logic [PW-1:0] max_len_next;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign job_pop   = (state_reg == ST_IDLE) && job_valid;
    assign out_free  = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == ST_COMMIT) && out_free;
    assign wr_en     = commit && !ovf_reg;

    always_comb
    begin
        col_start = column_start_reg[job_reg.ref_id];
        col_reset = (job_reg.start_pos > col_start)
                    && ((job_reg.start_pos - col_start) > col_dist_reg);
        cur_first = col_reset ? '0 : row_cursor_reg[job_reg.ref_id];
        cnt       = row_count_reg[job_reg.ref_id];
        occupied  = ({1'b0, cur_reg} < cnt) && (rd_data_reg >= {1'b0, job_reg.start_pos});
        is_last   = (cur_reg == LAST_ROW);
        max_end_next = (job_reg.end_pos > largest_end_reg[job_reg.ref_id])
                       ? job_reg.end_pos : largest_end_reg[job_reg.ref_id];
        max_len_next = (job_reg.read_len > largest_length_reg[job_reg.ref_id])
                       ? job_reg.read_len : largest_length_reg[job_reg.ref_id];
        rd_row = cur_reg;
        unique case (state_reg)
            ST_SETUP:
            begin
                rd_row = cur_first;
            end
            ST_SCAN:
            begin
                if (occupied && !is_last)
                begin
                    rd_row = cur_reg + RW'(1);
                end
            end
            default:
            begin
                rd_row = cur_reg;
            end
        endcase
    end

    // row end memory, one read and one write port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= row_mem[{job_reg.ref_id, rd_row}];
        if (wr_en)
        begin
            row_mem[{job_reg.ref_id, cur_reg}] <= job_reg.end_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        if (commit)
        begin
            out_data_reg.packed_row   <= 10'(cur_reg);
            out_data_reg.end_position <= job_reg.end_pos;
            out_data_reg.max_end      <= max_end_next;
            out_data_reg.max_length   <= max_len_next;
            out_data_reg.overflow     <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            ovf_reg       <= 1'b0;
            col_dist_reg  <= rrp_pkg::COL_DIST_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < rrp_pkg::NUM_REFS; i++)
            begin
                row_count_reg[i]      <= '0;
                row_cursor_reg[i]     <= '0;
                column_start_reg[i]   <= '0;
                largest_end_reg[i]    <= '0;
                largest_length_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                col_dist_reg <= cfg_data;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    cur_reg <= cur_first;
                    ovf_reg <= 1'b0;
                    if (col_reset)
                    begin
                        column_start_reg[job_reg.ref_id] <= job_reg.start_pos;
                    end
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (occupied && !is_last)
                    begin
                        cur_reg <= cur_reg + RW'(1);
                    end
                    else
                    begin
                        ovf_reg   <= occupied;
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    if (out_free)
                    begin
                        if (!ovf_reg && ({1'b0, cur_reg} >= cnt))
                        begin
                            row_count_reg[job_reg.ref_id] <= cnt + CW'(1);
                        end
                        row_cursor_reg[job_reg.ref_id]     <= cur_reg;
                        largest_end_reg[job_reg.ref_id]    <= max_end_next;
                        largest_length_reg[job_reg.ref_id] <= max_len_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/read_row_packer_core.sv
// read row packer top level: joins the front end queue and the back end
// row search; depends on rrp_pkg, rrp_front and rrp_back
//
// Usage
//   in_valid/in_stall/in_data carry one aligned read per transfer. Unmapped
//   reads are taken and dropped with no result. Every mapped read gives one
//   result on out_valid/out_stall/out_data: its row, end position, the
//   largest end and length so far on its reference, and the overflow flag.
//   cfg_valid/cfg_ready/cfg_data write the column distance; cfg_ready is
//   always high and writes belong only to idle periods.
// Flow
//   A read waits in the queue, then passes the back end states idle, setup,
//   scan and commit; scan steps over the stored rows from the cursor on whose
//   end reaches its start (one row end read per cycle), and commit registers
//   its result. The back end takes no new read before the last one commits.
// Reset: clears all per-reference counts, cursors, column starts and maxima
//   and loads the column distance with 100000; row ends need no clearing.
// Stalls
//   A stalled result holds in the output register; the back end waits with
//   its next result, while the two-entry queue keeps taking reads until full.
module read_row_packer_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rrp_pkg::rrp_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rrp_pkg::rrp_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [30:0]       cfg_data
);

    rrp_pkg::rrp_job_t job;
    logic              job_valid;
    logic              job_pop;

    assign cfg_ready = 1'b1;

    rrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    rrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: verif/tb_read_row_packer_core.sv
// testbench for read_row_packer_core: random and directed aligned reads with a
// self-checking row packing predictor, random idling on both channels
// depends on rrp_pkg and read_row_packer_core
module tb_read_row_packer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import rrp_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 24;
    localparam int MAX_REPORTS = 10;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    rrp_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    rrp_out_t out_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [POS_W-1:0] cfg_data = '0;

    rrp_in_t  pending_reads[$];
    rrp_out_t expected_results[$];

    // predictor state
    logic [END_W-1:0] row_end_mem [NUM_REFS][MAX_ROWS];
    logic [CNT_W-1:0] rows_open   [NUM_REFS];
    logic [ROW_W-1:0] cursor_row  [NUM_REFS];
    logic [POS_W-1:0] col_start   [NUM_REFS];
    logic [END_W-1:0] top_end     [NUM_REFS];
    logic [POS_W-1:0] top_len     [NUM_REFS];
    logic [POS_W-1:0] col_dist;

    // stimulus state
    logic [POS_W-1:0] next_start [NUM_REFS];
    bit               retired    [NUM_REFS];

    int  fail_count    = 0;
    int  cycle_count   = 0;
    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    int  src_gap       = 0;
    int  sink_gap      = 0;
    bit  quiet         = 1'b0;
    bit  in_taken      = 1'b0;

    read_row_packer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void clear_packing_state();
        for (int r = 0; r < NUM_REFS; r++)
        begin
            rows_open[r]  = '0;
            cursor_row[r] = '0;
            col_start[r]  = '0;
            top_end[r]    = '0;
            top_len[r]    = '0;
        end
        col_dist = COL_DIST_RESET;
    endfunction

    function automatic bit place_read(input rrp_in_t rd, output rrp_out_t res);
        int unsigned      r;
        int unsigned      cur;
        int unsigned      cnt;
        logic [END_W-1:0] end_v;
        bit               full;
        full = 1'b0;
        res  = '0;
        if (!rd.mapped)
            return 1'b0;
        r     = rd.reference_id;
        end_v = END_W'(rd.start_position) + END_W'(rd.read_length);
        if (rd.start_position > col_start[r] &&
            rd.start_position - col_start[r] > col_dist)
        begin
            cursor_row[r] = '0;
            col_start[r]  = rd.start_position;
        end
        cur = cursor_row[r];
        cnt = rows_open[r];
        while (cur < cnt && row_end_mem[r][cur] >= END_W'(rd.start_position))
        begin
            if (cur + 1 >= MAX_ROWS)
            begin
                full = 1'b1;
                break;
            end
            cur++;
        end
        if (!full)
        begin
            if (cur >= cnt)
                rows_open[r] = CNT_W'(cnt + 1);
            row_end_mem[r][cur] = end_v;
        end
        cursor_row[r] = ROW_W'(cur);
        if (end_v > top_end[r])
            top_end[r] = end_v;
        if (rd.read_length > top_len[r])
            top_len[r] = rd.read_length;
        res.packed_row   = 10'(cur);
        res.end_position = end_v;
        res.max_end      = top_end[r];
        res.max_length   = top_len[r];
        res.overflow     = full;
        return 1'b1;
    endfunction

    function automatic void compare_result(input rrp_out_t exp_r, input rrp_out_t got);
        if (exp_r.packed_row   !== got.packed_row   ||
            exp_r.end_position !== got.end_position ||
            exp_r.max_end      !== got.max_end      ||
            exp_r.max_length   !== got.max_length   ||
            exp_r.overflow     !== got.overflow)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
            begin
                $write("mismatch at %0t: expected row %0d end %0d max_end %0d max_len %0d",
                       $realtime, exp_r.packed_row, exp_r.end_position, exp_r.max_end,
                       exp_r.max_length);
                $write(" ovf %0b, got row %0d end %0d", exp_r.overflow, got.packed_row,
                       got.end_position);
                $display(" max_end %0d max_len %0d ovf %0b", got.max_end, got.max_length,
                         got.overflow);
            end
        end
    endfunction

    // monitor and predictor
    always @(posedge clk)
    begin
        rrp_out_t res;
        if (!rst_n)
        begin
            clear_packing_state();
            in_taken = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result at %0t: row %0d end %0d",
                                 $realtime, out_data.packed_row, out_data.end_position);
                end
                else
                    compare_result(expected_results.pop_front(), out_data);
            end
            in_taken = in_valid && !in_stall;
            if (in_taken && place_read(in_data, res))
                expected_results.push_back(res);
            if (cfg_valid && cfg_ready)
                col_dist = cfg_data;
        end
    end

    // read driver
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(99) < src_idle_pct)
            begin
                src_gap = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end
            else if (pending_reads.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_reads.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result stall driver
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            sink_gap--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(99) < sink_idle_pct)
        begin
            sink_gap = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic push_read(input bit m, input int unsigned r,
                             input logic [POS_W-1:0] s, input logic [POS_W-1:0] l);
        rrp_in_t rd;
        rd.mapped         = m;
        rd.reference_id   = 4'(r);
        rd.start_position = s;
        rd.read_length    = l;
        pending_reads.push_back(rd);
    endtask

    function automatic int unsigned pick_ref();
        int unsigned r;
        do
            r = $urandom_range(0, NUM_REFS - 1);
        while (retired[r]);
        return r;
    endfunction

    task automatic set_idling();
        src_idle_pct  = 15 * $urandom_range(0, 3);
        sink_idle_pct = 15 * $urandom_range(0, 3);
    endtask

    task automatic wait_queue_empty();
        do
            @(posedge clk);
        while (pending_reads.size() != 0);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_reads.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_column_distance(input logic [POS_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random_reads(input int n);
        int unsigned      pick;
        int unsigned      r;
        int               left;
        int               chunk;
        logic [POS_W-1:0] len;
        left = n;
        while (left > 0)
        begin
            chunk = (left > 100) ? 100 : left;
            left -= chunk;
            set_idling();
            repeat (chunk)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    push_read(1'b0, $urandom_range(0, NUM_REFS - 1), POS_W'($urandom),
                              POS_W'($urandom));
                else if (pick < 14)
                    push_read(1'b1, $urandom_range(0, NUM_REFS - 1), POS_W'($urandom),
                              POS_W'($urandom));
                else
                begin
                    r = pick_ref();
                    if ($urandom_range(99) < 5)
                        next_start[r] += POS_W'($urandom_range(0, 400000));
                    else
                        next_start[r] += POS_W'($urandom_range(0, 400));
                    if ($urandom_range(99) < 4)
                        len = POS_W'($urandom);
                    else
                        len = POS_W'($urandom_range(0, 1500));
                    push_read(1'b1, r, next_start[r], len);
                end
            end
            wait_queue_empty();
        end
    endtask

    // overlapping reads on one reference until every row is taken
    task automatic queue_row_stack();
        int unsigned r;
        r = pick_ref();
        retired[r] = 1'b1;
        repeat (MAX_ROWS + 16)
        begin
            next_start[r] += POS_W'($urandom_range(0, 50));
            push_read(1'b1, r, next_start[r],
                      POS_W'(32'h4000_0000 + $urandom_range(0, 1 << 20)));
        end
        wait_queue_empty();
    endtask

    initial
    begin
        for (int r = 0; r < NUM_REFS; r++)
        begin
            next_start[r] = '0;
            retired[r]    = 1'b0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling();
        push_read(1'b0, 7, POS_MAX, POS_MAX);
        push_read(1'b1, 0, 0, 0);
        push_read(1'b1, 0, 0, 0);
        push_read(1'b1, 15, POS_MAX, POS_MAX);
        push_read(1'b1, 15, 5, 3);
        push_read(1'b1, 1, 1000, 10);
        push_read(1'b1, 1, 1005, 10);
        push_read(1'b1, 1, 1020, 10);
        push_read(1'b1, 1, 200000, 0);
        push_read(1'b1, 2, 100000, 50);
        push_read(1'b1, 2, 100001, 50);
        push_read(1'b0, 2, 0, 0);
        push_read(1'b1, 3, 50, POS_MAX);
        push_read(1'b1, 3, 60, 0);
        push_read(1'b1, 3, 60, 1);
        push_read(1'b1, 3, 70, 5);
        wait_queue_empty();
        queue_random_reads(60);
        wait_drained();

        write_column_distance('0);
        queue_random_reads(50);
        wait_drained();

        write_column_distance(POS_MAX);
        set_idling();
        queue_row_stack();
        queue_random_reads(40);
        wait_drained();

        write_column_distance(POS_W'($urandom_range(1000, 50000)));
        queue_random_reads(50);
        wait_drained();

        write_column_distance(POS_W'($urandom));
        queue_random_reads(30);
        wait_drained();

        write_column_distance(POS_W'(5000));
        quiet = 1'b1;
        queue_random_reads(30);
        wait_drained();

        if (fail_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rrp_pkg.sv
hw/rtl/rrp_front.sv
hw/rtl/rrp_back.sv
hw/rtl/read_row_packer_core.sv
verif/tb_read_row_packer_core.sv
